@@ rtl/magng_pkg.sv @@
// Shared types, constants and sequencer codes for the mic AGC with noise gate.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package magng_pkg;

	// Fixed design constants
	localparam logic [7:0]  WINDOW_FRAMES = 8'd50;
	localparam logic [7:0]  HOLD_FRAMES   = 8'd15;
	localparam logic [15:0] NF_SMOOTH_Q16 = 16'd16384;
	localparam logic [23:0] NF_MIN_LEVEL  = 24'd256;
	localparam logic [16:0] AGC_MIN_Q12   = 17'd1024;
	localparam logic [16:0] AGC_MAX_Q12   = 17'd32768;
	localparam logic [15:0] ONE_Q12       = 16'd4096;
	localparam logic [17:0] GAIN_OUT_MAX  = 18'h3FFFF;

	// Datapath widths
	localparam int MUL_A_W = 24;
	localparam int MUL_B_W = 25;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int DIV_N_W = 43;
	localparam int DIV_D_W = 32;

	// ceil(2^31 / 100): x * RECIP_100 >> 31 equals x / 100 for any x below 2^24
	localparam logic [24:0] RECIP_100 = 25'd21474837;

	// Configuration register indexes
	localparam logic [2:0] REG_MANUAL_GAIN = 3'd0;
	localparam logic [2:0] REG_AGC_ENABLE  = 3'd1;
	localparam logic [2:0] REG_SPEECH_MULT = 3'd2;
	localparam logic [2:0] REG_SPEECH_MARG = 3'd3;
	localparam logic [2:0] REG_TARGET_PEAK = 3'd4;
	localparam logic [2:0] REG_ATTACK_RATE = 3'd5;
	localparam logic [2:0] REG_RELEASE     = 3'd6;
	localparam logic [2:0] REG_GATE_ATTEN  = 3'd7;

	// Divider request from the sequencer
	typedef struct packed {
		logic                 start;
		logic [DIV_N_W-1:0]   dividend;
		logic [DIV_D_W-1:0]   divisor;
	} div_req_t;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LVL,
		ST_LVLW,
		ST_NF,
		ST_NFW,
		ST_VOX,
		ST_VOXW,
		ST_NUM,
		ST_NUMW,
		ST_WDIV,
		ST_AGC,
		ST_AGCW,
		ST_G1,
		ST_G1W,
		ST_G2,
		ST_G2W,
		ST_GQ,
		ST_GQW,
		ST_ML,
		ST_MLW,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

@@ rtl/magng_mul.sv @@
// Shared registered multiplier of the AGC datapath.
// Depends on magng_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none
module magng_mul (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [magng_pkg::MUL_A_W-1:0] a,
	input  wire logic [magng_pkg::MUL_B_W-1:0] b,
	output logic      [magng_pkg::MUL_P_W-1:0] prod_q
);
	import magng_pkg::*;

	// Register the product when issued
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= MUL_P_W'(a) * MUL_P_W'(b);
		end
	end

endmodule
`default_nettype wire

@@ rtl/magng_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on magng_pkg for widths and the request struct.
`timescale 1ns / 1ps
`default_nettype none
module magng_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire magng_pkg::div_req_t           req,
	output logic                               done_q,
	output logic      [magng_pkg::DIV_N_W-1:0] quo_q
);
	import magng_pkg::*;

	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] dvs_q;
	logic [5:0]         cnt_q;
	logic               busy_q;
	logic [DIV_D_W:0]   shifted;
	logic               ge;

	// One shift-subtract step
	assign shifted = {rem_q, quo_q[DIV_N_W-1]};
	assign ge      = shifted >= {1'b0, dvs_q};

	// Control: count the steps, pulse done at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(DIV_N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load operands, then shift quotient bits in
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_D_W'(shifted - {1'b0, dvs_q}) : shifted[DIV_D_W-1:0];
			quo_q <= {quo_q[DIV_N_W-2:0], ge};
		end
	end

endmodule
`default_nettype wire

@@ rtl/mic_agc_noise_gate.sv @@
// Microphone AGC with noise gate: one frame peak in, one gain result out.
//
// Input channel: in_valid/in_stall carry frame_peak, one item per audio frame.
// Output channel: out_valid/out_stall carry target_gain, agc_report, voiced,
// gate_open and level_meter, one item for each input item.
// Configuration: cfg_we, cfg_index, cfg_data write one register per cycle;
// write only while no item is in flight.
//
// A sequencer runs one registered multiplier and one 43-step restoring
// divider. With AGC off an item skips the noise-floor, speech and gain
// steps; a frame with speech runs the wanted-gain division, which holds
// the sequencer until it is done, and the gain update, and a window end
// adds the noise-floor update. Divisions by constants use a reciprocal
// product. in_stall is high from acceptance until the result is loaded
// into the output register, so the next item may enter while a result
// waits, but not before. When the receiver stalls, the result holds in
// the output register and the sequencer waits before loading the following one.
// Reset clears the registers to their default values, the noise floor to
// its minimum, the window and gate to empty and the adaptive gain to 1.0.
// Depends on magng_pkg, magng_mul and magng_div.
`timescale 1ns / 1ps
`default_nettype none
module mic_agc_noise_gate (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [30:0] frame_peak,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [17:0] target_gain,
	output logic      [7:0]  agc_report,
	output logic             voiced,
	output logic             gate_open,
	output logic      [7:0]  level_meter,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import magng_pkg::*;

	// Configuration registers
	logic [7:0]  pct_q;
	logic        agc_en_q;
	logic [11:0] mult_q;
	logic [14:0] margin_q;
	logic [14:0] target_q;
	logic [15:0] attack_q;
	logic [15:0] release_q;
	logic [15:0] atten_q;

	// AGC state
	logic [23:0] nf_q;
	logic [23:0] wmin_q;
	logic [7:0]  wcnt_q;
	logic [7:0]  hold_q;
	logic [15:0] agc_q;

	// Per-item working registers
	state_t      state_q, state_d;
	logic [22:0] level_q;
	logic [30:0] lp_q;
	logic [23:0] pa_q;
	logic [23:0] dq_q;
	logic [16:0] want_q;
	logic [17:0] gain_q;
	logic [7:0]  ml_q;
	logic        voiced_q;
	logic        win_end_q;

	// Shared units
	logic               mul_en;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod;
	div_req_t           div_req;
	logic               div_done;
	logic [DIV_N_W-1:0] quo;

	// Helper values
	logic        nf_up;
	logic [23:0] nf_mag;
	logic [23:0] nf_step;
	logic [23:0] nf_new;
	logic        agc_up;
	logic [16:0] agc_mag;
	logic [16:0] agc_step;
	logic [16:0] agc_new;
	logic [7:0]  wcnt_inc;
	logic [36:0] vox_rhs;
	logic [31:0] den;
	logic        out_free;

	magng_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	magng_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done_q (div_done),
		.quo_q  (quo)
	);

	// Noise floor smoothing step
	assign nf_up   = wmin_q >= nf_q;
	assign nf_mag  = nf_up ? wmin_q - nf_q : nf_q - wmin_q;
	assign nf_step = 24'((prod + MUL_P_W'(32768)) >> 16);
	assign nf_new  = nf_up ? nf_q + nf_step : nf_q - nf_step;

	// Adaptive gain step
	assign agc_up   = want_q >= {1'b0, agc_q};
	assign agc_mag  = agc_up ? want_q - {1'b0, agc_q} : {1'b0, agc_q} - want_q;
	assign agc_step = 17'((prod + MUL_P_W'(32768)) >> 16);
	assign agc_new  = agc_up ? {1'b0, agc_q} + agc_step : {1'b0, agc_q} - agc_step;

	assign wcnt_inc = wcnt_q + 8'd1;
	assign vox_rhs  = {1'b0, prod[35:0]} + {6'd0, margin_q, 16'd0};
	assign den      = {1'b0, lp_q} + 32'd25600;
	assign out_free = !out_valid || !out_stall;
	assign in_stall = state_q != ST_IDLE;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q     <= 8'd100;
			agc_en_q  <= 1'b0;
			mult_q    <= 12'd512;
			margin_q  <= 15'd100;
			target_q  <= 15'd8000;
			attack_q  <= 16'd16384;
			release_q <= 16'd1311;
			atten_q   <= 16'd16384;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MANUAL_GAIN: pct_q     <= cfg_data[7:0];
				REG_AGC_ENABLE:  agc_en_q  <= cfg_data[0];
				REG_SPEECH_MULT: mult_q    <= cfg_data[11:0];
				REG_SPEECH_MARG: margin_q  <= cfg_data[14:0];
				REG_TARGET_PEAK: target_q  <= cfg_data[14:0];
				REG_ATTACK_RATE: attack_q  <= cfg_data;
				REG_RELEASE:     release_q <= cfg_data;
				REG_GATE_ATTEN:  atten_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, multiplier operands and divider requests
	always_comb begin
		state_d          = state_q;
		mul_en           = 1'b0;
		mul_a            = '0;
		mul_b            = '0;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_LVL;
			end
			ST_LVL: begin
				mul_en  = 1'b1;
				mul_a   = {1'b0, level_q};
				mul_b   = MUL_B_W'(pct_q);
				state_d = ST_LVLW;
			end
			ST_LVLW: begin
				if (!agc_en_q) state_d = ST_G1;
				else if (win_end_q) state_d = ST_NF;
				else state_d = ST_VOX;
			end
			ST_NF: begin
				mul_en  = 1'b1;
				mul_a   = nf_mag;
				mul_b   = MUL_B_W'(NF_SMOOTH_Q16);
				state_d = ST_NFW;
			end
			ST_NFW: state_d = ST_VOX;
			ST_VOX: begin
				mul_en  = 1'b1;
				mul_a   = nf_q;
				mul_b   = MUL_B_W'(mult_q);
				state_d = ST_VOXW;
			end
			ST_VOXW: begin
				state_d = ({6'd0, level_q, 8'd0} > vox_rhs) ? ST_NUM : ST_G1;
			end
			ST_NUM: begin
				mul_en  = 1'b1;
				mul_a   = {9'd0, target_q};
				mul_b   = MUL_B_W'(100);
				state_d = ST_NUMW;
			end
			ST_NUMW: begin
				div_req.start    = 1'b1;
				div_req.dividend = {prod[21:0], 20'd0} + DIV_N_W'(den >> 1);
				div_req.divisor  = den;
				state_d          = ST_WDIV;
			end
			ST_WDIV: begin
				if (div_done) state_d = ST_AGC;
			end
			ST_AGC: begin
				mul_en  = 1'b1;
				mul_a   = {7'd0, agc_mag};
				mul_b   = MUL_B_W'((want_q < {1'b0, agc_q}) ? attack_q : release_q);
				state_d = ST_AGCW;
			end
			ST_AGCW: state_d = ST_G1;
			ST_G1: begin
				mul_en  = 1'b1;
				mul_a   = {8'd0, agc_q};
				mul_b   = MUL_B_W'(pct_q);
				state_d = ST_G1W;
			end
			ST_G1W: begin
				if (!agc_en_q || hold_q != 8'd0) state_d = ST_GQ;
				else state_d = ST_G2;
			end
			ST_G2: begin
				mul_en  = 1'b1;
				mul_a   = pa_q;
				mul_b   = MUL_B_W'(atten_q);
				state_d = ST_G2W;
			end
			ST_G2W: state_d = ST_GQ;
			// Divide the rounded gain by 100 with the reciprocal
			ST_GQ: begin
				mul_en  = 1'b1;
				mul_a   = dq_q;
				mul_b   = RECIP_100;
				state_d = ST_GQW;
			end
			ST_GQW: state_d = ST_ML;
			// Mic level: (level * pct >> 8) / 100
			ST_ML: begin
				mul_en  = 1'b1;
				mul_a   = {1'b0, lp_q[30:8]};
				mul_b   = RECIP_100;
				state_d = ST_MLW;
			end
			ST_MLW: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// AGC state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nf_q      <= NF_MIN_LEVEL;
			wmin_q    <= '1;
			wcnt_q    <= '0;
			hold_q    <= '0;
			agc_q     <= ONE_Q12;
			win_end_q <= 1'b0;
			voiced_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_LVL: begin
					if (agc_en_q) begin
						if (level_q < wmin_q[22:0] || wmin_q[23]) wmin_q <= {1'b0, level_q};
						wcnt_q    <= wcnt_inc;
						win_end_q <= wcnt_inc >= WINDOW_FRAMES;
					end
				end
				ST_LVLW: begin
					voiced_q <= 1'b0;
					if (!agc_en_q) begin
						nf_q   <= NF_MIN_LEVEL;
						wmin_q <= '1;
						wcnt_q <= '0;
						hold_q <= '0;
						agc_q  <= ONE_Q12;
					end
				end
				ST_NFW: begin
					nf_q   <= (nf_new < NF_MIN_LEVEL) ? NF_MIN_LEVEL : nf_new;
					wmin_q <= {1'b0, level_q};
					wcnt_q <= '0;
				end
				ST_VOXW: begin
					if ({6'd0, level_q, 8'd0} > vox_rhs) begin
						voiced_q <= 1'b1;
						hold_q   <= HOLD_FRAMES;
					end else if (hold_q != 8'd0) begin
						hold_q <= hold_q - 8'd1;
					end
				end
				ST_AGCW: agc_q <= agc_new[15:0];
				default: ;
			endcase
		end
	end

	// Per-item payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) level_q <= frame_peak[30:8];
		if (state_q == ST_LVLW) lp_q <= prod[30:0];
		if (state_q == ST_G1W) begin
			pa_q <= prod[23:0];
			dq_q <= prod[23:0] + 24'd50;
		end
		if (state_q == ST_G2W) dq_q <= 24'((prod + MUL_P_W'(3276800)) >> 16);
		if (state_q == ST_WDIV && div_done) begin
			if (quo < DIV_N_W'(AGC_MIN_Q12)) want_q <= AGC_MIN_Q12;
			else if (quo > DIV_N_W'(AGC_MAX_Q12)) want_q <= AGC_MAX_Q12;
			else want_q <= quo[16:0];
		end
		if (state_q == ST_GQW) gain_q <= prod[48:31];
		if (state_q == ST_MLW) ml_q <= (prod[48:31] > 18'd32767) ? 8'hFF : prod[45:38];
	end

	// Output register: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid <= 1'b1;
		end else if (out_valid && !out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			target_gain <= gain_q;
			agc_report  <= (agc_q[15:8] > 8'd255) ? 8'd255 : agc_q[15:8];
			voiced      <= voiced_q;
			gate_open   <= hold_q != 8'd0;
			level_meter <= ml_q;
		end
	end

endmodule
`default_nettype wire
